FILE: hw/rtl/lmf_pkg.sv
`default_nettype none

package lmf_pkg;

    // grid limits and value width
    localparam int MAX_ROWS  = 4096;
    localparam int MAX_COLS  = 1024;
    localparam int VAL_W     = 32;

    // field widths
    localparam int IN_VAL_W  = 32;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 10;
    localparam int ROWS_W    = 13;
    localparam int COLS_W    = 11;
    localparam int NUM_W     = 21;
    localparam int BANK_W    = 2;
    localparam int BANKS     = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL = 2'd3;

    // input opcodes
    localparam logic IN_CELL  = 1'b0;
    localparam logic IN_DRAIN = 1'b1;

    // result kinds
    localparam logic K_PEAK    = 1'b0;
    localparam logic K_VERDICT = 1'b1;

    // job operations between front and back
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_CELL  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [NUM_W-1:0] PEAK_MAX = '1;

    // queue sizes
    localparam int JQ_DEPTH   = 2;
    localparam int JQ_PTR_W   = 1;
    localparam int JQ_CNT_W   = 2;
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_PTR_W   = 2;
    localparam int RQ_CNT_W   = 3;

    typedef logic [VAL_W-1:0] t_key;

    typedef struct packed {
        logic                       opcode;
        logic signed [IN_VAL_W-1:0] cell_value;
    } t_item;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  peak_row;
        logic [COL_W-1:0]  peak_col;
        logic [NUM_W-1:0]  peak_number;
        logic              target_hit;
        logic              last;
    } t_res;

    // one classified item, as handed from front to back
    typedef struct packed {
        logic [1:0]        op;
        logic              restart;
        t_key              key;
        logic [COL_W-1:0]  col;
        logic [BANK_W-1:0] wbank;
        logic [BANK_W-1:0] abank;
        logic [BANK_W-1:0] bbank;
        logic [ROW_W-1:0]  drow;
        logic [COL_W-1:0]  dcol;
        logic              top;
        logic              below;
        logic              left;
        logic              right;
        logic              dec1;
        logic              dec2;
        logic              hit1;
        logic              hit2;
        logic              ends_grid;
    } t_job;

    // one column of the 3x3 window
    typedef struct packed {
        t_key top;
        t_key mid;
        t_key bot;
    } t_col;

    // signed value to order-preserving unsigned key
    function automatic t_key value_key(logic signed [IN_VAL_W-1:0] v);
        return {~v[VAL_W-1], v[VAL_W-2:0]};
    endfunction

    function automatic logic [BANK_W-1:0] bank_inc(logic [BANK_W-1:0] b);
        return (b == BANK_W'(BANKS - 1)) ? '0 : b + BANK_W'(1);
    endfunction

    function automatic logic [BANK_W-1:0] bank_dec(logic [BANK_W-1:0] b);
        return (b == '0) ? BANK_W'(BANKS - 1) : b - BANK_W'(1);
    endfunction

    function automatic logic [NUM_W-1:0] sat_inc(logic [NUM_W-1:0] x);
        return (x == PEAK_MAX) ? x : x + NUM_W'(1);
    endfunction

    // centre is the middle of column m; absent neighbours are skipped
    function automatic logic is_peak(t_col l, t_col m, t_col r, logic top, logic below,
                                     logic left, logic right);
        logic ok;
        t_key c;
        c  = m.mid;
        ok = 1'b1;
        if (top && !(c > m.top)) ok = 1'b0;
        if (below && !(c > m.bot)) ok = 1'b0;
        if (left) begin
            if (!(c > l.mid)) ok = 1'b0;
            if (top && !(c > l.top)) ok = 1'b0;
            if (below && !(c > l.bot)) ok = 1'b0;
        end
        if (right) begin
            if (!(c > r.mid)) ok = 1'b0;
            if (top && !(c > r.top)) ok = 1'b0;
            if (below && !(c > r.bot)) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/grid_strict_local_maximum_finder_top.sv
`default_nettype none

// strict 3x3 local-maximum finder for a grid streamed in raster order, one
// signed value per beat (opcode cell); a cell is a peak when it beats every
// neighbour that exists, edges and corners simply have fewer neighbours.
// each peak comes out as a report with row, column and running ordinal
// (saturating at the top of the 21-bit field); after the last cell the host
// sends num_cols drain beats, which settle the bottom row, and the last of
// them also yields the verdict with the total count and the target hit flag.
// rate: one beat per clock sustained while the result queue has room, cells
// and drain beats alike. the pace is set by the row store, three banks of
// max_cols words each doing one write and two reads per cycle, and by the
// result queue, which needs two free slots before a beat is finished, so an
// unread result queue throttles input.
// the row store needs no clearing after reset: only cells already written in
// the current grid are ever read. grid size and target are taken from the
// registers as each beat arrives; a size change that leaves the current
// position outside the grid drops the grid in progress and starts afresh.
// rows and columns below two are taken as two, above the limits as the limit.
// configuration writes are meant for idle moments only.

module grid_strict_local_maximum_finder_top import lmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input side
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output t_res                  o_result,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic accept;
    logic jq_push, jq_full, jq_empty, jq_pop;
    t_job front_job, back_job;

    // a beat is taken whenever the job queue has a slot
    assign accept = push && !jq_full;
    assign full   = jq_full;

    // front: position tracking, grid restart and classification
    lmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job_push  (jq_push),
        .o_job       (front_job)
    );

    // short queue so front and back stall on their own
    lmf_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_job   (front_job),
        .o_full  (jq_full),
        .o_empty (jq_empty),
        .i_pop   (jq_pop),
        .o_job   (back_job)
    );

    // back: row store, window compare, peak count and result queue
    lmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job       (back_job),
        .o_job_take  (jq_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    // the verdict carries no coordinates
    a_verdict_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.last) |->
        (o_result.kind == K_VERDICT && o_result.peak_row == '0 && o_result.peak_col == '0))
        else $error("verdict with peak fields set");

    // a peak report always carries an ordinal of at least one
    a_peak_number : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == K_PEAK) |-> (o_result.peak_number != '0))
        else $error("peak report with zero ordinal");

    // a last-column decision always comes with the diagonal one of a cell beat
    a_two_decisions : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (jq_push && front_job.dec2) |-> (front_job.dec1 && front_job.op == OP_CELL))
        else $error("second decision without first");

    // drain beats never write the row store and never request a second peak
    a_drain_job : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (jq_push && front_job.op == OP_DRAIN) |-> (!front_job.dec2 && !front_job.below))
        else $error("drain job with a row below");

endmodule

`default_nettype wire

FILE: hw/rtl/lmf_front.sv
`default_nettype none

module lmf_front import lmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_item                 i_item,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_job_push,
    output t_job                  o_job
);

    logic [ROWS_W-1:0] r_num_rows;
    logic [COLS_W-1:0] r_num_cols;
    logic [ROW_W-1:0]  r_target_row;
    logic [COL_W-1:0]  r_target_col;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [BANK_W-1:0] r_bank, n_bank;
    logic              r_drain, n_drain;

    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              restart;
    logic [ROW_W-1:0]  row, up;
    logic [COL_W-1:0]  col, lc;
    logic [BANK_W-1:0] bank;
    logic              drain;
    logic              row_last, col_last;
    t_job              job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= ROWS_W'(2);
            r_num_cols   <= COLS_W'(2);
            r_target_row <= '0;
            r_target_col <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_NUM_ROWS:   r_num_rows   <= i_cfg_wdata[ROWS_W-1:0];
                REG_NUM_COLS:   r_num_cols   <= i_cfg_wdata[COLS_W-1:0];
                REG_TARGET_ROW: r_target_row <= i_cfg_wdata[ROW_W-1:0];
                REG_TARGET_COL: r_target_col <= i_cfg_wdata[COL_W-1:0];
            endcase
        end
    end

    always_comb begin
        rows_eff = (r_num_rows < ROWS_W'(2)) ? ROWS_W'(2) :
                   (r_num_rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : r_num_rows;
        cols_eff = (r_num_cols < COLS_W'(2)) ? COLS_W'(2) :
                   (r_num_cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : r_num_cols;

        // grid abandoned when the position no longer fits the configured size
        restart = ({1'b0, r_row} >= rows_eff) || ({1'b0, r_col} >= cols_eff) ||
                  (r_drain && (({1'b0, r_row} + ROWS_W'(1)) != rows_eff));

        row   = restart ? '0 : r_row;
        col   = restart ? '0 : r_col;
        bank  = restart ? '0 : r_bank;
        drain = restart ? 1'b0 : r_drain;

        row_last = (({1'b0, row} + ROWS_W'(1)) == rows_eff);
        col_last = (({1'b0, col} + COLS_W'(1)) == cols_eff);
        up = row - ROW_W'(1);
        lc = col - COL_W'(1);

        job         = '0;
        job.op      = OP_NOP;
        job.restart = restart;
        job.key     = value_key(i_item.cell_value);
        job.col     = col;

        n_row   = row;
        n_col   = col;
        n_bank  = bank;
        n_drain = drain;

        if (i_item.opcode == IN_CELL) begin
            if (!drain) begin
                job.op    = OP_CELL;
                job.wbank = bank;
                job.abank = bank_dec(bank);
                job.bbank = bank_inc(bank);
                job.drow  = up;
                job.dcol  = lc;
                job.top   = (row > ROW_W'(1));
                job.below = 1'b1;
                job.left  = (col > COL_W'(1));
                job.right = 1'b1;
                job.dec1  = (row != '0) && (col != '0);
                job.dec2  = (row != '0) && col_last;
                job.hit1  = (up == r_target_row) && (lc == r_target_col);
                job.hit2  = (up == r_target_row) && (col == r_target_col);
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_drain = 1'b1;
                    end else begin
                        n_row  = row + ROW_W'(1);
                        n_bank = bank_inc(bank);
                    end
                end else begin
                    n_col = col + COL_W'(1);
                end
            end
        end else if (drain) begin
            job.op        = OP_DRAIN;
            job.abank     = bank;
            job.bbank     = bank_dec(bank);
            job.drow      = row;
            job.dcol      = col;
            job.top       = (row != '0);
            job.below     = 1'b0;
            job.left      = (col != '0);
            job.right     = !col_last;
            job.dec1      = 1'b1;
            job.hit1      = (row == r_target_row) && (col == r_target_col);
            job.ends_grid = col_last;
            if (col_last) begin
                n_row   = '0;
                n_col   = '0;
                n_bank  = '0;
                n_drain = 1'b0;
            end else begin
                n_col = col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_bank  <= '0;
            r_drain <= 1'b0;
        end else if (i_accept) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_bank  <= n_bank;
            r_drain <= n_drain;
        end
    end

    assign o_job_push = i_accept;
    assign o_job      = job;

endmodule

`default_nettype wire

FILE: hw/rtl/lmf_jobq.sv
`default_nettype none

module lmf_jobq import lmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_job
);

    t_job                r_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] r_wp, r_rp;
    logic [JQ_CNT_W-1:0] r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == JQ_CNT_W'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + JQ_PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + JQ_PTR_W'(1);
            r_cnt <= r_cnt + JQ_CNT_W'(do_push) - JQ_CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lmf_back.sv
`default_nettype none

module lmf_back import lmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_take,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_result
);

    // stage 1: row store access, stage 2: window compare and result queue
    logic              s1_fire, s2_fire;
    logic              r_s2_valid;
    t_job              r_s2_job;
    logic [COL_W-1:0]  col_p1;
    logic              we;

    t_key              rd0 [BANKS];
    t_key              rd1 [BANKS];

    t_col              r_w1, r_w2;
    logic [NUM_W-1:0]  r_cnt;
    logic              r_hit;

    t_res              r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_rq_wp, r_rq_rp, rq_wp1;
    logic [RQ_CNT_W-1:0] r_rq_cnt;
    logic              rq_room, rq_pop;

    t_job              job;
    t_key              a0, b0, a1, b1;
    t_col              new_col, l1, c1, rc1;
    logic              p1, p2;
    logic [NUM_W-1:0]  cnt0, cnt1, cnt2;
    logic              hit0, hitf;
    t_res              res_a, res_b, first;
    logic              v0, v1;

    function automatic t_key pick3(logic [BANK_W-1:0] s, t_key x0, t_key x1, t_key x2);
        t_key v;
        unique case (s)
            2'd0:    v = x0;
            2'd1:    v = x1;
            default: v = x2;
        endcase
        return v;
    endfunction

    assign rq_room    = (r_rq_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign s2_fire    = r_s2_valid && rq_room;
    assign s1_fire    = i_job_valid && (!r_s2_valid || s2_fire);
    assign o_job_take = s1_fire;
    assign col_p1     = i_job.col + COL_W'(1);
    assign we         = s1_fire && (i_job.op == OP_CELL);

    // three row banks, ring by row modulo three
    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        t_key r_mem [MAX_COLS];
        t_key r_q0, r_q1;

        always_ff @(posedge i_clk) begin
            if (we && (i_job.wbank == BANK_W'(g))) begin
                r_mem[i_job.col] <= i_job.key;
            end
            if (s1_fire) begin
                r_q0 <= r_mem[i_job.col];
                r_q1 <= r_mem[col_p1];
            end
        end

        assign rd0[g] = r_q0;
        assign rd1[g] = r_q1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_fire) begin
            r_s2_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) r_s2_job <= i_job;
    end

    always_comb begin
        job = r_s2_job;
        a0  = pick3(job.abank, rd0[0], rd0[1], rd0[2]);
        b0  = pick3(job.bbank, rd0[0], rd0[1], rd0[2]);
        a1  = pick3(job.abank, rd1[0], rd1[1], rd1[2]);
        b1  = pick3(job.bbank, rd1[0], rd1[1], rd1[2]);

        new_col = '{top: b0, mid: a0, bot: job.key};
        if (job.op == OP_DRAIN) begin
            l1  = r_w1;
            c1  = '{top: b0, mid: a0, bot: '0};
            rc1 = '{top: b1, mid: a1, bot: '0};
        end else begin
            l1  = r_w2;
            c1  = r_w1;
            rc1 = new_col;
        end

        p1 = job.dec1 && is_peak(l1, c1, rc1, job.top, job.below, job.left, job.right);
        p2 = job.dec2 && is_peak(r_w1, new_col, new_col, job.top, 1'b1, 1'b1, 1'b0);

        cnt0 = job.restart ? '0 : r_cnt;
        hit0 = job.restart ? 1'b0 : r_hit;
        cnt1 = p1 ? sat_inc(cnt0) : cnt0;
        cnt2 = p2 ? sat_inc(cnt1) : cnt1;
        hitf = hit0 | (p1 & job.hit1) | (p2 & job.hit2);

        res_a = '{kind: K_PEAK, peak_row: job.drow, peak_col: job.dcol,
                  peak_number: cnt1, target_hit: job.hit1, last: 1'b0};
        if (p2) begin
            res_b = '{kind: K_PEAK, peak_row: job.drow, peak_col: job.col,
                      peak_number: cnt2, target_hit: job.hit2, last: 1'b0};
        end else begin
            res_b = '{kind: K_VERDICT, peak_row: '0, peak_col: '0,
                      peak_number: cnt2, target_hit: hitf, last: 1'b1};
        end

        first = p1 ? res_a : res_b;
        v0    = s2_fire && (p1 || p2 || job.ends_grid);
        v1    = s2_fire && p1 && (p2 || job.ends_grid);
    end

    // window shift and running totals
    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            if (job.op == OP_CELL) begin
                r_w2 <= r_w1;
                r_w1 <= new_col;
            end else if (job.op == OP_DRAIN) begin
                r_w1 <= c1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (s2_fire) begin
            r_cnt <= job.ends_grid ? '0 : cnt2;
            r_hit <= job.ends_grid ? 1'b0 : hitf;
        end
    end

    // result queue, up to two writes a cycle
    assign rq_wp1   = r_rq_wp + RQ_PTR_W'(1);
    assign o_empty  = (r_rq_cnt == '0);
    assign rq_pop   = i_pop && !o_empty;
    assign o_result = r_rq[r_rq_rp];

    always_ff @(posedge i_clk) begin
        if (v0) r_rq[r_rq_wp] <= first;
        if (v1) r_rq[rq_wp1]  <= res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= '0;
            r_rq_rp  <= '0;
            r_rq_cnt <= '0;
        end else begin
            r_rq_wp  <= r_rq_wp + RQ_PTR_W'(v0) + RQ_PTR_W'(v1);
            if (rq_pop) r_rq_rp <= r_rq_rp + RQ_PTR_W'(1);
            r_rq_cnt <= r_rq_cnt + RQ_CNT_W'(v0) + RQ_CNT_W'(v1) - RQ_CNT_W'(rq_pop);
        end
    end

endmodule

`default_nettype wire
